// ===== rtl/core/sha1mh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1mh_pkg: shared types and constants
// Payload structs, SHA-1 constants and the back-end state enum.
// ----------------------------------------------------------------------------
package sha1mh_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Command from front end to back end
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_EMIT
  } bk_state_t;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

endpackage

// ===== rtl/core/sha1mh_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1mh_front: input stage and command queue
// Drops empty non-final items and queues the rest for the back end.
// ----------------------------------------------------------------------------
module sha1mh_front #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  sha1mh_pkg::in_item_t in_item,
  input  logic                in_valid,
  output logic                in_ready,
  output sha1mh_pkg::cmd_t    cmd,
  output logic                cmd_valid,
  input  logic                cmd_ready
);
  import sha1mh_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  cmd_t          mem [Depth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          push;
  logic          pop;
  logic          take;

  assign in_ready  = (count != (AW+1)'(Depth));
  assign take      = in_valid && in_ready;
  // items with neither byte nor end do nothing
  assign push      = take && (in_item.has_byte || in_item.end_of_message);
  assign cmd_valid = (count != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = mem[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data: in_item.msg_byte, has_byte: in_item.has_byte,
                       last: in_item.end_of_message};
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

// ===== rtl/core/sha1mh_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1mh_core: block packing, padding and 80-round compression
// One round per cycle on a rolling 16-word schedule; emits the digest.
// ----------------------------------------------------------------------------
module sha1mh_core (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1mh_pkg::cmd_t     cmd,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output sha1mh_pkg::out_item_t out_item,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import sha1mh_pkg::*;

  bk_state_t   state, state_next;
  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  pos;
  logic [63:0] bit_length;
  logic [6:0]  round;
  logic        final_blk;
  logic [2:0]  emit_idx;
  logic        pad_pending;
  logic        len_done;

  logic        put_en;
  logic [7:0]  put_val;
  logic        wr_len;
  logic [31:0] wt, sched, f, k, tmp;
  logic [3:0]  ridx;

  assign ridx  = round[3:0];
  assign sched = w[ridx - 4'd3] ^ w[ridx - 4'd8] ^ w[ridx - 4'd14] ^ w[ridx];
  assign wt    = (round < 7'd16) ? w[ridx] : {sched[30:0], sched[31]};

  // round function
  always_comb begin
    if (round < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
    tmp = {a[26:0], a[31:27]} + f + e + k + wt;
  end

  // control
  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    put_en     = 1'b0;
    put_val    = cmd.data;
    wr_len     = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          put_en = cmd.has_byte;
          if (cmd.has_byte && pos == 6'd63) state_next = S_ROUND;
          else if (cmd.last)                 state_next = S_PAD;
        end
      end
      S_PAD: begin
        // the 0x80 marker, then zeros up to byte 56
        put_en  = 1'b1;
        put_val = final_blk ? PAD_BYTE : 8'h00;
        if (pos == 6'd63)      state_next = S_ROUND;
        else if (pos == 6'd55) state_next = S_LEN;
      end
      S_LEN: begin
        wr_len     = 1'b1;
        state_next = S_ROUND;
      end
      S_ROUND: if (round == 7'd79) state_next = S_ADD;
      // pending padding, finished message, or back to bytes
      S_ADD: begin
        if (pad_pending)   state_next = S_PAD;
        else if (len_done) state_next = S_EMIT;
        else               state_next = S_IDLE;
      end
      S_EMIT:  if (out_ready && emit_idx == 3'd4) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_EMIT);
  assign out_item  = '{digest_word: h[emit_idx], word_index: emit_idx,
                       last_word: (emit_idx == 3'd4)};

  // datapath and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pos        <= '0;
      bit_length <= '0;
      round      <= '0;
      final_blk  <= 1'b0;
      emit_idx   <= '0;
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end else begin
      state <= state_next;
      // final_blk marks "0x80 not yet placed" while padding is pending
      if (state == S_IDLE && cmd_valid && cmd.last) final_blk <= 1'b1;
      if (state == S_IDLE && cmd_valid && cmd.has_byte)
        bit_length <= bit_length + 64'd8;
      if (put_en) begin
        if (pos[1:0] == 2'd0) w[pos[5:2]] <= {put_val, 24'h0};
        else w[pos[5:2]] <= w[pos[5:2]] | ({24'h0, put_val} << (8 * (3 - pos[1:0])));
        pos <= pos + 6'd1;
        if (state == S_PAD) final_blk <= 1'b0;
      end
      if (wr_len) begin
        w[14] <= bit_length[63:32];
        w[15] <= bit_length[31:0];
        pos   <= '0;
      end
      if (state_next == S_ROUND && state != S_ROUND) begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
        round <= '0;
      end
      if (state == S_ROUND) begin
        if (round >= 7'd16) w[ridx] <= wt;
        e <= d; d <= c; c <= {b[1:0], b[31:2]}; b <= a; a <= tmp;
        round <= round + 7'd1;
      end
      if (state == S_ADD) begin
        h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
        h[3] <= h[3] + d; h[4] <= h[4] + e;
      end
      if (state == S_EMIT && out_ready) begin
        emit_idx <= emit_idx + 3'd1;
        if (emit_idx == 3'd4) begin
          emit_idx   <= '0;
          bit_length <= '0;
          h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
        end
      end
    end
  end

  // track where a message stands across block boundaries
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_pending <= 1'b0;
      len_done    <= 1'b0;
    end else begin
      if (state == S_IDLE && cmd_valid && cmd.last) pad_pending <= 1'b1;
      if (wr_len) begin
        pad_pending <= 1'b0;
        len_done    <= 1'b1;
      end
      if (state == S_ADD && !pad_pending) len_done <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/sha1_message_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_message_hasher: SHA-1 over a byte stream
// Queued front end feeding a round-per-cycle compression back end.
// ----------------------------------------------------------------------------
// channel | direction | payload
// in      | input     | msg_byte, has_byte, end_of_message
// out     | output    | digest_word, word_index, last_word
//
// The back end takes one byte per cycle while idle; each full block adds 80
// rounds and one add. An end item adds padding, one length step, one or two
// compressions, and five digest transactions. Rounds are the limit.
// Reset restores the initial chain. The input queue keeps accepting, until
// it is full, while the back end compresses or waits on the output.
// ----------------------------------------------------------------------------
module sha1_message_hasher #(
  parameter int QueueDepth = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  sha1mh_pkg::in_item_t in_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  output sha1mh_pkg::out_item_t out_data,
  output logic                 out_valid,
  input  logic                 out_ready
);
  import sha1mh_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  sha1mh_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst, .in_item(in_data), .in_valid, .in_ready,
    .cmd, .cmd_valid, .cmd_ready
  );

  sha1mh_core u_core (
    .clk, .rst, .cmd, .cmd_valid, .cmd_ready,
    .out_item(out_data), .out_valid, .out_ready
  );

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.last_word == (out_data.word_index == 3'd4)))
    else $error("last_word mismatch");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.word_index <= 3'd4))
    else $error("word_index out of range");
  a_no_pop_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !cmd_ready)
    else $error("queue popped during digest output");

endmodule

// ===== bench/tb_sha1_message_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_hasher: self-checking bench for the SHA-1 byte hasher
// Drives byte transactions with random gaps, predicts digests with an
// independent SHA-1 model and checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb_sha1_message_hasher;
  import sha1mh_pkg::*;

  // Digest predictor and ordered store of expected digest words
  class digest_scoreboard;
    logic [31:0] chain[5];
    logic [31:0] blk[16];
    int unsigned pos;
    logic [63:0] nbits;
    out_item_t   pending[$];
    int          errors;

    function new();
      init_chain();
      pos = 0;
      nbits = 0;
      errors = 0;
    endfunction

    function void init_chain();
      chain[0] = 32'h67452301; chain[1] = 32'hefcdab89; chain[2] = 32'h98badcfe;
      chain[3] = 32'h10325476; chain[4] = 32'hc3d2e1f0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, e, f, k, w, tmp;
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int t = 0; t < 80; t++) begin
        if (t >= 16)
          blk[t & 15] = rol(blk[(t - 3) & 15] ^ blk[(t - 8) & 15] ^
                            blk[(t - 14) & 15] ^ blk[t & 15], 1);
        w = blk[t & 15];
        if (t < 20) begin
          f = (b & c) | (~b & d); k = 32'h5A827999;
        end else if (t < 40) begin
          f = b ^ c ^ d; k = 32'h6ED9EBA1;
        end else if (t < 60) begin
          f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
        end else begin
          f = b ^ c ^ d; k = 32'hCA62C1D6;
        end
        tmp = rol(a, 5) + f + e + k + w;
        e = d; d = c; c = rol(b, 30); b = a; a = tmp;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    function void push_byte(logic [7:0] v);
      int sh;
      sh = (3 - (pos & 3)) * 8;
      if ((pos & 3) == 0) blk[pos >> 2] = 32'(v) << sh;
      else blk[pos >> 2] |= 32'(v) << sh;
      pos = (pos + 1) & 63;
      if (pos == 0) compress();
    endfunction

    // Note an accepted input transaction
    function void note_input(in_item_t it);
      out_item_t o;
      if (it.has_byte) begin
        push_byte(it.msg_byte);
        nbits += 8;
      end
      if (!it.end_of_message) return;
      push_byte(8'h80);
      while (pos != 56) push_byte(8'h00);
      blk[14] = nbits[63:32];
      blk[15] = nbits[31:0];
      compress();
      pos = 0;
      for (int i = 0; i < 5; i++) begin
        o.digest_word = chain[i];
        o.word_index = 3'(i);
        o.last_word = (i == 4);
        pending.push_back(o);
      end
      init_chain();
      nbits = 0;
    endfunction

    // Check an accepted output transaction against the oldest expectation
    function void check_output(out_item_t got);
      out_item_t exp_w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected output %h", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got !== exp_w) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp word %h idx %0d last %b, got word %h idx %0d last %b",
                   exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                   got.digest_word, got.word_index, got.last_word);
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst = 1;
  in_item_t  in_data = '0;
  logic      in_valid = 0;
  logic      in_ready;
  out_item_t out_data;
  logic      out_valid;
  logic      out_ready = 0;
  logic      no_idle = 0;
  digest_scoreboard sb = new();

  sha1_message_hasher i_dut (
    .clk(clk), .rst(rst), .in_data(in_data), .in_valid(in_valid),
    .in_ready(in_ready), .out_data(out_data), .out_valid(out_valid),
    .out_ready(out_ready)
  );

  always #1 clk = ~clk;

  // Output side: random stalls, check every accepted transaction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(out_data);
    out_ready <= no_idle || ($urandom_range(99) >= 14);
  end

  // Send one transaction, with an optional random gap before it
  task automatic send_item(logic [7:0] b, logic hb, logic eom);
    while (!no_idle && $urandom_range(99) < 14) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_data <= '{msg_byte: b, has_byte: hb, end_of_message: eom};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(in_data);
  endtask

  // Stop offering input transactions
  task automatic idle_input();
    in_valid <= 0;
  endtask

  // One message of n bytes; the final byte may ride on the end transaction
  task automatic send_message(int n, bit byte_on_end);
    for (int i = 0; i < n; i++)
      send_item(8'($urandom), 1, byte_on_end && (i == n - 1));
    if (!byte_on_end || n == 0) send_item(8'($urandom), 0, 1);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: empty message, extreme bytes, idle items
    send_item(8'h00, 0, 1);
    send_item(8'hff, 1, 1);
    send_item(8'h00, 1, 0);
    send_item(8'hff, 0, 0);
    send_item(8'h5a, 0, 0);
    send_item(8'h00, 1, 1);
    send_item(8'ha5, 1, 0);
    send_item(8'h00, 0, 1);
    // Hold off until all digests are out
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    // Two-block padding, with random gaps
    send_message(56, 1'b0);
    // Full block ending on the end transaction, with no idling at all
    no_idle = 1;
    send_message(64, 1'b1);
    no_idle = 0;
    // Random short messages
    for (int m = 0; m < 3; m++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 0, 0);
      send_message($urandom_range(4), 1'($urandom_range(1)));
    end
    idle_input();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== sha1_message_hasher.f =====
rtl/core/sha1mh_pkg.sv
rtl/core/sha1mh_front.sv
rtl/core/sha1mh_core.sv
rtl/core/sha1_message_hasher.sv
bench/tb_sha1_message_hasher.sv
